### hdl/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

	// pipeline depth, input beat to output beat
	localparam int NUM_STAGES = 11;

	// config register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SENS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_OFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SENS_TC     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TC      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REF    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFF  = 3'd5;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_coeff;
	} psc_cfg_t;

	// temperature: 20.00 C base, -15.00 C low-temp knee (relative to base)
	localparam logic [18:0] TEMP_BASE    = 19'd2000;
	localparam logic [18:0] KNEE_OFFSET  = 19'd3500;
	localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
	localparam logic signed [19:0] TEMP_MIN_W = -20'sd4000;
	localparam logic signed [19:0] TEMP_MAX_W = 20'sd8500;

	// pressure limits, in 0.1 mbar and in mbar
	localparam logic [27:0] PRESS_DECI_MAX = 28'd140000;
	localparam logic [13:0] PRESS_MAX      = 14'd14000;

	// x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for x < 2^19
	localparam logic [18:0] DIV10_MUL   = 19'd419431;
	localparam int          DIV10_SHIFT = 22;

endpackage

### hdl/pressure_sensor_compensation.sv
`timescale 1ns / 1ps

// Second-order compensated barometric sensor math. Each input beat carries one
// raw temperature and one raw pressure conversion; each output beat carries the
// temperature in 0.01 C (clamped to -40.00..85.00 C) and the pressure in whole
// mbar (clamped to 0..14000). The six calibration words are written through the
// cfg channel (index 0..5, reset 0) and must only change while the pipe is
// empty. The datapath is an 11-stage pipeline: one beat per clock sustained
// while m_tready is high. A beat lands in stage 1 at its accepting edge and
// moves on stage by stage to stage 11, whose valid bit drives m_tvalid.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and the input keeps flowing while a
// finished result waits on the output, until all 11 stages hold a beat.
module pressure_sensor_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,   // [23:0] raw_temp, [47:24] raw_press
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [14:0] temp_centi, [28:15] press_mbar,
	                                                  // [31:29] zero
	// calibration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);

	localparam int NS = psc_pkg::NUM_STAGES;

	psc_pkg::psc_cfg_t cfg;

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeffs    (cfg)
	);

	// ---------------------------------------------------------------------
	// pipeline flow control: stage k loads when empty or when k+1 loads
	// ---------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	// ---------------------------------------------------------------------
	// S1: dT = D2 - C5*2^8
	// ---------------------------------------------------------------------
	logic        [23:0] d1_s1;
	logic signed [24:0] dt_s1;
	logic        [24:0] dt_c;

	assign dt_c = {1'b0, s_tdata[23:0]} - {1'b0, cfg.reference_temperature, 8'd0};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= s_tdata[47:24];
			dt_s1 <= dt_c;
		end
	end

	// ---------------------------------------------------------------------
	// S2: the four products of dT
	// ---------------------------------------------------------------------
	logic signed [41:0] dtc6_c, c4dt_c, c3dt_c;
	logic signed [49:0] dtsq_c;
	logic signed [41:0] dtc6_s2, c4dt_s2, c3dt_s2;
	logic        [47:0] dtsq_s2;
	logic        [23:0] d1_s2;

	assign dtc6_c = dt_s1 * $signed({1'b0, cfg.temperature_coeff});
	assign c4dt_c = dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
	assign c3dt_c = dt_s1 * $signed({1'b0, cfg.sensitivity_temp_coeff});
	assign dtsq_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dtc6_s2 <= dtc6_c;
			c4dt_s2 <= c4dt_c;
			c3dt_s2 <= c3dt_c;
			dtsq_s2 <= dtsq_c[47:0];
			d1_s2   <= d1_s1;
		end
	end

	// ---------------------------------------------------------------------
	// S3: first-order TEMP, OFF, SENS; T2 for both branches
	// cold (TEMP < 20 C) is dTmp < 0; very cold (TEMP < -15 C) is TEMP+1500 < 0
	// ---------------------------------------------------------------------
	logic signed [17:0] dtmp_c;
	logic        [18:0] tp_c, temp1_c;
	logic        [35:0] off_c;
	logic        [34:0] sens_c;
	logic        [16:0] t2_c;
	logic        [14:0] t2_cold;
	logic        [10:0] t2_warm;

	logic signed [17:0] dtmp_s3;
	logic signed [18:0] tp_s3, temp1_s3;
	logic signed [35:0] off_s3;
	logic signed [34:0] sens_s3;
	logic        [16:0] t2_s3;
	logic               cold_s3, vcold_s3;
	logic        [23:0] d1_s3;

	assign dtmp_c  = dtc6_s2[40:23];
	assign temp1_c = {dtmp_c[17], dtmp_c} + psc_pkg::TEMP_BASE;
	assign tp_c    = {dtmp_c[17], dtmp_c} + psc_pkg::KNEE_OFFSET;
	assign off_c   = {4'd0, cfg.pressure_offset, 16'd0} + {c4dt_s2[41], c4dt_s2[41:7]};
	assign sens_c  = {4'd0, cfg.pressure_sensitivity, 15'd0} + {c3dt_s2[41], c3dt_s2[41:8]};
	assign t2_cold = dtsq_s2[47:33];
	assign t2_warm = dtsq_s2[47:37];
	assign t2_c    = dtmp_c[17] ? ({2'd0, t2_cold} + {1'b0, t2_cold, 1'b0})
	                            : ({3'd0, t2_warm, 3'd0} - {6'd0, t2_warm});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dtmp_s3  <= dtmp_c;
			tp_s3    <= tp_c;
			temp1_s3 <= temp1_c;
			off_s3   <= off_c;
			sens_s3  <= sens_c;
			t2_s3    <= t2_c;
			cold_s3  <= dtmp_c[17];
			vcold_s3 <= tp_c[18];
			d1_s3    <= d1_s2;
		end
	end

	// ---------------------------------------------------------------------
	// S4: dTmp^2, (TEMP+1500)^2, final temperature with clamp
	// ---------------------------------------------------------------------
	logic signed [35:0] sq_c;
	logic signed [37:0] lo_c;
	logic signed [19:0] temp2_c;
	logic signed [14:0] tclamp_c;

	logic        [33:0] sq_s4, lo_s4;
	logic signed [14:0] temp_s4;
	logic signed [35:0] off_s4;
	logic signed [34:0] sens_s4;
	logic               cold_s4, vcold_s4;
	logic        [23:0] d1_s4;

	assign sq_c    = dtmp_s3 * dtmp_s3;
	assign lo_c    = tp_s3 * tp_s3;
	assign temp2_c = {temp1_s3[18], temp1_s3} - {3'd0, t2_s3};

	always_comb begin
		if (temp2_c < psc_pkg::TEMP_MIN_W) begin
			tclamp_c = psc_pkg::TEMP_MIN;
		end else if (temp2_c > psc_pkg::TEMP_MAX_W) begin
			tclamp_c = psc_pkg::TEMP_MAX;
		end else begin
			tclamp_c = temp2_c[14:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sq_s4    <= sq_c[33:0];
			lo_s4    <= lo_c[33:0];
			temp_s4  <= tclamp_c;
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
			cold_s4  <= cold_s3;
			vcold_s4 <= vcold_s3;
			d1_s4    <= d1_s3;
		end
	end

	// ---------------------------------------------------------------------
	// S5: OFF2 and SENS2
	// ---------------------------------------------------------------------
	logic [35:0] sq3_c;
	logic [36:0] sq5_c, lo7_c;
	logic [37:0] off2_c;
	logic [36:0] sens2_c;

	logic        [37:0] off2_s5;
	logic        [36:0] sens2_s5;
	logic signed [14:0] temp_s5;
	logic signed [35:0] off_s5;
	logic signed [34:0] sens_s5;
	logic        [23:0] d1_s5;

	assign sq3_c = {2'd0, sq_s4} + {1'b0, sq_s4, 1'b0};
	assign sq5_c = {3'd0, sq_s4} + {1'b0, sq_s4, 2'd0};
	assign lo7_c = {lo_s4, 3'd0} - {3'd0, lo_s4};

	always_comb begin
		if (cold_s4) begin
			off2_c  = {3'd0, sq3_c[35:1]} + (vcold_s4 ? {1'b0, lo7_c} : 38'd0);
			sens2_c = {3'd0, sq5_c[36:3]} + (vcold_s4 ? {1'b0, lo_s4, 2'd0} : 37'd0);
		end else begin
			off2_c  = {8'd0, sq_s4[33:4]};
			sens2_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			temp_s5  <= temp_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			d1_s5    <= d1_s4;
		end
	end

	// ---------------------------------------------------------------------
	// S6: OFF -= OFF2, SENS -= SENS2
	// ---------------------------------------------------------------------
	logic signed [39:0] off_s6;
	logic signed [38:0] sens_s6;
	logic signed [14:0] temp_s6;
	logic        [23:0] d1_s6;
	logic        [39:0] offn_c;
	logic        [38:0] sensn_c;

	assign offn_c  = {{4{off_s5[35]}}, off_s5} - {2'd0, off2_s5};
	assign sensn_c = {{4{sens_s5[34]}}, sens_s5} - {2'd0, sens2_s5};

	always_ff @(posedge clk) begin
		if (en[5]) begin
			off_s6  <= offn_c;
			sens_s6 <= sensn_c;
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
		end
	end

	// ---------------------------------------------------------------------
	// S7: D1*SENS as two partial products (low 20 bits / signed high part)
	// ---------------------------------------------------------------------
	logic        [43:0] plo_c;
	logic signed [43:0] phi_c;
	logic        [43:0] plo_s7;
	logic signed [43:0] phi_s7;
	logic signed [39:0] off_s7;
	logic signed [14:0] temp_s7;

	assign plo_c = d1_s6 * sens_s6[19:0];
	assign phi_c = $signed({1'b0, d1_s6}) * $signed(sens_s6[38:20]);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			plo_s7  <= plo_c;
			phi_s7  <= phi_c;
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
	end

	// ---------------------------------------------------------------------
	// S8: combine partial products
	// ---------------------------------------------------------------------
	logic        [63:0] prod_c;
	logic signed [63:0] prod_s8;
	logic signed [39:0] off_s8;
	logic signed [14:0] temp_s8;

	assign prod_c = {phi_s7, 20'd0} + {20'd0, plo_s7};

	always_ff @(posedge clk) begin
		if (en[7]) begin
			prod_s8 <= prod_c;
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// ---------------------------------------------------------------------
	// S9: P = (D1*SENS/2^21 - OFF) / 2^15 in 0.1 mbar, range flags
	// ---------------------------------------------------------------------
	logic [43:0] pp_c;
	logic [28:0] p_c;
	logic        pneg_c, pbig_c;

	logic        [17:0] p_s9;
	logic               pneg_s9, pbig_s9;
	logic signed [14:0] temp_s9;

	assign pp_c   = {prod_s8[63], prod_s8[63:21]} - {{4{off_s8[39]}}, off_s8};
	assign p_c    = pp_c[43:15];
	assign pneg_c = p_c[28];
	assign pbig_c = !pneg_c && (p_c[27:0] >= psc_pkg::PRESS_DECI_MAX);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			p_s9    <= p_c[17:0];
			pneg_s9 <= pneg_c;
			pbig_s9 <= pbig_c;
			temp_s9 <= temp_s8;
		end
	end

	// ---------------------------------------------------------------------
	// S10: divide by ten via reciprocal multiply
	// ---------------------------------------------------------------------
	logic        [36:0] pq_c;
	logic        [36:0] pq_s10;
	logic               pneg_s10, pbig_s10;
	logic signed [14:0] temp_s10;

	assign pq_c = p_s9 * psc_pkg::DIV10_MUL;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			pq_s10   <= pq_c;
			pneg_s10 <= pneg_s9;
			pbig_s10 <= pbig_s9;
			temp_s10 <= temp_s9;
		end
	end

	// ---------------------------------------------------------------------
	// S11: output register, pressure clamp
	// ---------------------------------------------------------------------
	logic        [13:0] mbar_c;
	logic        [13:0] mbar_s11;
	logic signed [14:0] temp_s11;

	always_comb begin
		if (pneg_s10) begin
			mbar_c = '0;
		end else if (pbig_s10) begin
			mbar_c = psc_pkg::PRESS_MAX;
		end else begin
			mbar_c = pq_s10[psc_pkg::DIV10_SHIFT +: 14];
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			mbar_s11 <= mbar_c;
			temp_s11 <= temp_s10;
		end
	end

	assign m_tvalid = vld_q[NS-1];
	assign m_tdata  = {3'd0, mbar_s11, temp_s11};

`ifndef ASSERT_OFF
	temp_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (temp_s11 >= psc_pkg::TEMP_MIN && temp_s11 <= psc_pkg::TEMP_MAX))
		else $error("temperature beat outside clamp range");

	press_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mbar_s11 <= psc_pkg::PRESS_MAX))
		else $error("pressure beat outside clamp range");

	accept_fills_a: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted beat not captured in first stage");

	empty_out_ready_a: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NS-1] |-> s_tready)
		else $error("input stalled while output stage empty");
`endif

endmodule

### hdl/psc_cfg.sv
`timescale 1ns / 1ps

module psc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	output psc_pkg::psc_cfg_t              coeffs
);

	psc_pkg::psc_cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign coeffs    = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				psc_pkg::CFG_PRESS_SENS: begin
					regs_q.pressure_sensitivity <= cfg_data;
				end
				psc_pkg::CFG_PRESS_OFF: begin
					regs_q.pressure_offset <= cfg_data;
				end
				psc_pkg::CFG_SENS_TC: begin
					regs_q.sensitivity_temp_coeff <= cfg_data;
				end
				psc_pkg::CFG_OFF_TC: begin
					regs_q.offset_temp_coeff <= cfg_data;
				end
				psc_pkg::CFG_TEMP_REF: begin
					regs_q.reference_temperature <= cfg_data;
				end
				psc_pkg::CFG_TEMP_COEFF: begin
					regs_q.temperature_coeff <= cfg_data;
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the second-order barometric compensation pipe.
// A sender task drives raw temperature/pressure beats, a sink process throttles
// the output, and a negedge monitor checks every output beat against a
// predictor kept here in plain 64-bit signed arithmetic.
module tb;

	localparam int CLK_HALF          = 5;
	localparam int RESET_CYCLES      = 7;
	localparam int CYCLE_LIMIT       = 500000;
	localparam int MAX_REPORTS       = 10;
	localparam int LONG_STALL_CYCLES = 150;
	localparam int BURST_BEATS       = 40;
	localparam int CAL_SETS          = 6;
	localparam int BEATS_PER_SET     = 65;

	// spare index codes, outside the six calibration words
	localparam logic [psc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [psc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// compensation knees, in 0.01 C
	localparam longint WARM_KNEE = 2000;
	localparam longint COLD_KNEE = -1500;

	// datasheet-style calibration, C1..C6 in field order
	localparam psc_pkg::psc_cfg_t CAL_TYPICAL = '{16'd46372, 16'd43981, 16'd29059,
		16'd27842, 16'd31553, 16'd28165};
	localparam psc_pkg::psc_cfg_t CAL_ZERO = '0;
	localparam psc_pkg::psc_cfg_t CAL_ONES = '1;

	typedef struct packed {
		logic signed [14:0] temp_centi;
		logic [13:0]        press_mbar;
	} reading_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [47:0]                   s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [31:0]                   m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [psc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                   cfg_data = '0;

	// calibration as the predictor sees it; follows every accepted write
	psc_pkg::psc_cfg_t cal = CAL_ZERO;

	reading_t expected_readings[$];
	int       mismatches = 0;
	int       cycle_count = 0;

	// idling controls: src_gaps lives in the stimulus process only,
	// sink_gaps is handed to the sink process by NBA
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;

	// long output hold-off: stimulus bumps the request count, sink serves it
	int stall_requests = 0;
	int stall_served = 0;
	int hold_left = 0;

	reading_t beat_seen;
	reading_t beat_want;

	pressure_sensor_compensation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// mostly back-to-back, some short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Expected reading for one raw sample pair under the current calibration.
	// All >>> are on signed 64-bit values, so they floor; / truncates.
	function automatic reading_t compensate(input logic [23:0] t_raw,
		input logic [23:0] p_raw);
		longint d_temp, d_press, c1, c2, c3, c4, c5, c6;
		longint dtemp, dtemp_scaled, temp, off, sens, dsq, sq;
		longint corr_t, corr_off, corr_sens, cold, deci, mbar;
		reading_t r;
		d_temp = t_raw;
		d_press = p_raw;
		c1 = cal.pressure_sensitivity;
		c2 = cal.pressure_offset;
		c3 = cal.sensitivity_temp_coeff;
		c4 = cal.offset_temp_coeff;
		c5 = cal.reference_temperature;
		c6 = cal.temperature_coeff;

		dtemp = d_temp - c5 * 256;
		dtemp_scaled = (dtemp * c6) >>> 23;
		temp = WARM_KNEE + dtemp_scaled;
		off = c2 * 65536 + ((c4 * dtemp) >>> 7);
		sens = c1 * 32768 + ((c3 * dtemp) >>> 8);
		dsq = dtemp * dtemp;
		sq = dtemp_scaled * dtemp_scaled;

		// second-order term, split at 20.00 C, extra term below -15.00 C
		if (temp < WARM_KNEE) begin
			corr_t = 3 * (dsq >>> 33);
			corr_off = 3 * sq / 2;
			corr_sens = 5 * sq / 8;
			if (temp < COLD_KNEE) begin
				cold = (temp - COLD_KNEE) * (temp - COLD_KNEE);
				corr_off += 7 * cold;
				corr_sens += 4 * cold;
			end
		end else begin
			corr_t = 7 * (dsq >>> 37);
			corr_off = sq / 16;
			corr_sens = 0;
		end
		temp -= corr_t;
		off -= corr_off;
		sens -= corr_sens;

		deci = (((d_press * sens) >>> 21) - off) >>> 15;
		mbar = deci / 10;

		if (temp < psc_pkg::TEMP_MIN_W)
			temp = psc_pkg::TEMP_MIN_W;
		if (temp > psc_pkg::TEMP_MAX_W)
			temp = psc_pkg::TEMP_MAX_W;
		if (mbar < 0)
			mbar = 0;
		if (mbar > longint'(psc_pkg::PRESS_MAX))
			mbar = longint'(psc_pkg::PRESS_MAX);
		r.temp_centi = temp[14:0];
		r.press_mbar = mbar[13:0];
		return r;
	endfunction

	// raw temperature: some uniform, most near the reference point at
	// random spans so all branches of the correction get exercised
	function automatic logic [23:0] pick_raw_temp();
		longint centre, v;
		int span, spread;
		if ($urandom_range(0, 9) < 4)
			return 24'($urandom());
		centre = longint'(cal.reference_temperature) * 256;
		span = 1 << $urandom_range(8, 21);
		spread = $urandom_range(0, 2 * span);
		v = centre + longint'(spread) - longint'(span);
		if (v < 0)
			v = 0;
		if (v > 16777215)
			v = 16777215;
		return v[23:0];
	endfunction

	function automatic logic [23:0] pick_raw_press();
		if ($urandom_range(0, 1) == 0)
			return 24'($urandom());
		return 24'($urandom_range(0, 24'h7FFFFF));
	endfunction

	function automatic logic [15:0] pick_cal_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// Output sink: random tready, or a counted hold-off when one is asked for.
	always @(posedge clk) begin
		if (stall_served != stall_requests) begin
			stall_served <= stall_requests;
			hold_left <= LONG_STALL_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (sink_gaps)
				hold_left <= pick_gap();
		end
	end

	// Output monitor. Inputs only move at posedge, so what is stable at the
	// negedge is what the next posedge handshake will see.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			beat_seen.temp_centi = m_tdata[14:0];
			beat_seen.press_mbar = m_tdata[28:15];
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("tb: unexpected output beat: temp %0d press %0d",
						beat_seen.temp_centi, beat_seen.press_mbar);
			end else begin
				beat_want = expected_readings.pop_front();
				if (beat_want != beat_seen) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("tb: mismatch: expected temp %0d press %0d, got temp %0d press %0d",
							beat_want.temp_centi, beat_want.press_mbar,
							beat_seen.temp_centi, beat_seen.press_mbar);
				end
			end
		end
	end

	// One input beat. Called at a posedge, returns at the posedge that took
	// the beat. tvalid is left high so back-to-back beats need no toggle.
	task automatic send_sample(input logic [23:0] t_raw, input logic [23:0] p_raw);
		int gap;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p_raw, t_raw};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		expected_readings.push_back(compensate(t_raw, p_raw));
		@(posedge clk);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// one calibration write; cfg_valid drops again before return, keeping cfg_valid edges apart
	task automatic write_reg(input logic [psc_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			psc_pkg::CFG_PRESS_SENS: cal.pressure_sensitivity = val;
			psc_pkg::CFG_PRESS_OFF:  cal.pressure_offset = val;
			psc_pkg::CFG_SENS_TC:    cal.sensitivity_temp_coeff = val;
			psc_pkg::CFG_OFF_TC:     cal.offset_temp_coeff = val;
			psc_pkg::CFG_TEMP_REF:   cal.reference_temperature = val;
			psc_pkg::CFG_TEMP_COEFF: cal.temperature_coeff = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_cal(input psc_pkg::psc_cfg_t c);
		write_reg(psc_pkg::CFG_PRESS_SENS, c.pressure_sensitivity);
		write_reg(psc_pkg::CFG_PRESS_OFF, c.pressure_offset);
		write_reg(psc_pkg::CFG_SENS_TC, c.sensitivity_temp_coeff);
		write_reg(psc_pkg::CFG_OFF_TC, c.offset_temp_coeff);
		write_reg(psc_pkg::CFG_TEMP_REF, c.reference_temperature);
		write_reg(psc_pkg::CFG_TEMP_COEFF, c.temperature_coeff);
	endtask

	// all-zero calibration straight out of reset, raw extremes
	task automatic test_reset_calibration();
		send_sample(24'h000000, 24'h000000);
		send_sample(24'hFFFFFF, 24'hFFFFFF);
		send_sample(24'hFFFFFF, 24'h000000);
		send_sample(24'h000000, 24'hFFFFFF);
		send_sample(24'h800000, 24'h400000);
		drain();
	endtask

	// typical calibration: both sides of 20 C, the cold branch, all clamps
	task automatic test_typical_calibration();
		write_cal(CAL_TYPICAL);
		send_sample(24'd8077636, 24'd4311550);
		send_sample(24'd8077568, 24'd4311550);  // exactly 20.00 C, warm branch
		send_sample(24'd8077567, 24'd4311550);  // one count under, cold branch
		send_sample(24'd6977568, 24'd4311550);  // below -15 C, extra term
		send_sample(24'h000000, 24'd4311550);   // temperature clamps low
		send_sample(24'hFFFFFF, 24'd4311550);   // temperature clamps high
		send_sample(24'd8077636, 24'h000000);   // negative pressure -> 0
		send_sample(24'd8077636, 24'hFFFFFF);   // pressure clamps high
		send_sample(24'd8500000, 24'd6000000);
		send_sample(24'd7700000, 24'd3000000);
		drain();
	endtask

	// full-scale and zero calibration; spare indexes must change nothing
	task automatic test_calibration_extremes();
		write_cal(CAL_ONES);
		write_reg(CFG_SPARE_LO, 16'h5A5A);
		write_reg(CFG_SPARE_HI, 16'h0000);
		send_sample(24'h000000, 24'h000000);
		send_sample(24'hFFFFFF, 24'hFFFFFF);
		send_sample(24'hFFFF00, 24'h800000);
		send_sample(24'hFFFEFF, 24'h800000);
		drain();
		write_cal(CAL_ZERO);
		send_sample(24'hFFFFFF, 24'h123456);
		send_sample(24'h000000, 24'hFFFFFF);
		drain();
	endtask

	// random samples over several calibrations; set 1 runs with no idling
	task automatic test_random_samples();
		psc_pkg::psc_cfg_t c;
		for (int k = 0; k < CAL_SETS; k++) begin
			drain();
			if (k == 0)
				c = CAL_TYPICAL;
			else
				c = '{pick_cal_word(), pick_cal_word(), pick_cal_word(),
					pick_cal_word(), pick_cal_word(), pick_cal_word()};
			write_cal(c);
			src_gaps = (k != 1);
			sink_gaps <= (k != 1);
			repeat (BEATS_PER_SET)
				send_sample(pick_raw_temp(), pick_raw_press());
		end
		drain();
		src_gaps = 1'b1;
		sink_gaps <= 1'b1;
	endtask

	// sink holds off for a long stretch while beats keep coming, so the
	// pipe fills and input tready drops; then sender waits for a full drain
	task automatic test_output_backpressure();
		write_cal(CAL_TYPICAL);
		src_gaps = 1'b0;
		stall_requests <= stall_requests + 1;
		repeat (BURST_BEATS)
			send_sample(pick_raw_temp(), pick_raw_press());
		drain();
		src_gaps = 1'b1;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_typical_calibration();
		test_calibration_extremes();
		test_output_backpressure();
		test_random_samples();

		// nothing else may show up on the output
		drain();
		repeat (psc_pkg::NUM_STAGES + 10) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
